[src/ims_pkg.sv]
// ----------------------------------------------------------------------------
// ims_pkg: shared types and constants for the interval merge sorter
// Entry type and default capacity.
// ----------------------------------------------------------------------------
package ims_pkg;

  localparam int unsigned MAX_INTERVALS_DEF = 32;

  // one queued interval from the front end to the sorter
  typedef struct packed {
    logic signed [31:0] start_v;
    logic signed [31:0] end_v;
    logic               last_v;
  } ims_entry_t;

endpackage

[src/ims_front.sv]
// ----------------------------------------------------------------------------
// ims_front: input stage and queue
// Registers accepted words into a two-entry queue ahead of the sorter.
// ----------------------------------------------------------------------------
module ims_front
  import ims_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_interval_start,
  input  logic signed [31:0] in_interval_end,
  input  logic               in_last_interval,
  output logic               q_valid,
  input  logic               q_pop,
  output ims_entry_t         q_data
);

  ims_entry_t q_r [2];
  logic       rd_r, wr_r;
  logic [1:0] cnt_r;
  logic       push;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = q_r[rd_r];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_r] <= '{start_v: in_interval_start, end_v: in_interval_end,
                     last_v: in_last_interval};
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r <= 1'b0; wr_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wr_r <= ~wr_r;
      if (q_pop) rd_r <= ~rd_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

[src/ims_back.sv]
// ----------------------------------------------------------------------------
// ims_back: insertion sort array and merge scan
// Systolic-style parallel insertion, then a merge scan of one entry per cycle, held while a word waits on output stall.
// ----------------------------------------------------------------------------
module ims_back
  import ims_pkg::*;
#(
  parameter int unsigned MAX_INTERVALS = MAX_INTERVALS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_pop,
  input  ims_entry_t         q_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_merged_start,
  output logic signed [31:0] out_merged_end,
  output logic               out_last_merged,
  output logic               out_capacity_exceeded
);

  localparam int unsigned CW = $clog2(MAX_INTERVALS + 1);
  localparam int unsigned IW = $clog2(MAX_INTERVALS);

  typedef enum logic [1:0] {S_FILL, S_SCAN, S_FLUSH} state_t;

  logic signed [31:0] st_r [MAX_INTERVALS];
  logic signed [31:0] en_r [MAX_INTERVALS];
  logic [CW-1:0]      cnt_r;
  logic [IW-1:0]      idx_r;
  logic               ovf_r;
  state_t             state_r;
  logic signed [31:0] cs_r, ce_r;
  logic               full;
  logic               gt [MAX_INTERVALS];
  logic               gt_prev [MAX_INTERVALS];
  logic signed [31:0] st_prev [MAX_INTERVALS];
  logic signed [31:0] en_prev [MAX_INTERVALS];
  logic               ins;
  logic               out_free;
  logic               ovl;
  logic               word_out;

  assign full     = (cnt_r == CW'(MAX_INTERVALS));
  assign out_free = !out_valid || !out_stall;
  assign q_pop    = (state_r == S_FILL) && q_valid;
  assign ins      = q_pop && !full;
  assign ovl      = (st_r[idx_r] <= ce_r);
  assign word_out = out_free && ((state_r == S_FLUSH) ||
                                 (state_r == S_SCAN && idx_r != '0 && !ovl));

  // per-slot compare: stored key above new key; neighbor below each slot
  always_comb begin
    for (int i = 0; i < MAX_INTERVALS; i++) begin
      gt[i] = (st_r[i] > q_data.start_v) ||
              (st_r[i] == q_data.start_v && en_r[i] > q_data.end_v);
    end
    gt_prev[0] = 1'b0;
    st_prev[0] = q_data.start_v;
    en_prev[0] = q_data.end_v;
    for (int i = 1; i < MAX_INTERVALS; i++) begin
      gt_prev[i] = gt[i-1];
      st_prev[i] = st_r[i-1];
      en_prev[i] = en_r[i-1];
    end
  end

  // sorted array: shift up where greater, insert at boundary
  always_ff @(posedge clk) begin
    if (ins) begin
      for (int i = 0; i < MAX_INTERVALS; i++) begin
        if (i == int'(cnt_r) || (i < int'(cnt_r) && gt[i])) begin
          if (gt_prev[i]) begin
            st_r[i] <= st_prev[i]; en_r[i] <= en_prev[i];
          end else begin
            st_r[i] <= q_data.start_v; en_r[i] <= q_data.end_v;
          end
        end
      end
    end
  end

  // control: fill, scan, final flush
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_FILL; cnt_r <= '0; ovf_r <= 1'b0; idx_r <= '0;
      out_valid <= 1'b0;
    end else begin
      if (word_out) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      unique case (state_r)
        S_FILL: begin
          if (q_pop) begin
            if (full) ovf_r <= 1'b1;
            else      cnt_r <= cnt_r + CW'(1);
            if (q_data.last_v) begin
              state_r <= S_SCAN;
              idx_r   <= '0;
            end
          end
        end
        S_SCAN: begin
          if (idx_r == '0) begin
            cs_r <= st_r[0]; ce_r <= en_r[0];
            if (cnt_r == CW'(1)) state_r <= S_FLUSH;
            else idx_r <= IW'(1);
          end else if (ovl) begin
            if (en_r[idx_r] > ce_r) ce_r <= en_r[idx_r];
            if ({1'b0, idx_r} + (IW+1)'(1) == (IW+1)'(cnt_r)) state_r <= S_FLUSH;
            else idx_r <= idx_r + IW'(1);
          end else if (out_free) begin
            out_merged_start <= cs_r; out_merged_end <= ce_r;
            out_last_merged <= 1'b0; out_capacity_exceeded <= ovf_r;
            cs_r <= st_r[idx_r]; ce_r <= en_r[idx_r];
            if ({1'b0, idx_r} + (IW+1)'(1) == (IW+1)'(cnt_r)) state_r <= S_FLUSH;
            else idx_r <= idx_r + IW'(1);
          end
        end
        S_FLUSH: begin
          if (out_free) begin
            out_merged_start <= cs_r; out_merged_end <= ce_r;
            out_last_merged <= 1'b1; out_capacity_exceeded <= ovf_r;
            cnt_r <= '0; ovf_r <= 1'b0; state_r <= S_FILL;
          end
        end
        default: state_r <= S_FILL;
      endcase
    end
  end

endmodule

[src/interval_merge_sorter_unit.sv]
// ----------------------------------------------------------------------------
// interval_merge_sorter_unit: sort intervals by start, merge overlaps
// Front queue feeding a parallel insertion sorter and merge scanner.
// ----------------------------------------------------------------------------
// channel | ports                                     | direction
// in      | in_valid/in_stall, start, end, last       | input
// out     | out_valid/out_stall, start, end, last, ov | output
// Inputs are inserted one per cycle while filling (all slots compare at once).
// After the last word the scan walks the stored entries in order,
// emitting one merged word per gap; the next set waits for the scan to end.
// Synchronous active-low reset empties the store and the queue.
// Output stall holds the scan; input stall rises when the queue is full.
// ----------------------------------------------------------------------------
module interval_merge_sorter_unit
  import ims_pkg::*;
#(
  parameter int unsigned MAX_INTERVALS = MAX_INTERVALS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_interval_start,
  input  logic signed [31:0] in_interval_end,
  input  logic               in_last_interval,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_merged_start,
  output logic signed [31:0] out_merged_end,
  output logic               out_last_merged,
  output logic               out_capacity_exceeded
);

  ims_entry_t q_data;
  logic       q_valid, q_pop;

  ims_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_interval_start, .in_interval_end,
    .in_last_interval, .q_valid, .q_pop, .q_data
  );

  ims_back #(.MAX_INTERVALS(MAX_INTERVALS)) u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_data, .out_valid, .out_stall,
    .out_merged_start, .out_merged_end, .out_last_merged, .out_capacity_exceeded
  );

endmodule

[src/ims_checker.sv]
// ----------------------------------------------------------------------------
// ims_checker: port-level checks for the interval merge sorter
// Watches output ordering and handshake behavior.
// ----------------------------------------------------------------------------
module ims_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_merged_start,
  input logic signed [31:0] out_merged_end,
  input logic               out_last_merged,
  input logic               out_capacity_exceeded
);

  logic               in_run_r;
  logic signed [31:0] prev_end_r;
  logic               prev_ovf_r;

  // track the previous accepted word of the current run
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_run_r <= 1'b0; prev_end_r <= '0; prev_ovf_r <= 1'b0;
    end else if (out_valid && !out_stall) begin
      in_run_r   <= !out_last_merged;
      prev_end_r <= out_merged_end;
      prev_ovf_r <= out_capacity_exceeded;
    end
  end

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_merged_start) &&
    $stable(out_merged_end) && $stable(out_last_merged) &&
    $stable(out_capacity_exceeded))
    else $error("stalled output changed");

  // merged words within a run ascend with a gap
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && in_run_r |-> out_merged_start > prev_end_r)
    else $error("merged words out of order");

  // overflow flag constant within a run
  a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && in_run_r |-> out_capacity_exceeded == prev_ovf_r)
    else $error("overflow flag changed within a run");

  // valid is always known out of reset
  a_known: assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown(out_valid))
    else $error("output valid unknown");

endmodule

bind interval_merge_sorter_unit ims_checker u_ims_checker (
  .clk, .rst_n, .out_valid, .out_stall, .out_merged_start, .out_merged_end,
  .out_last_merged, .out_capacity_exceeded
);

[tb/sv/interval_merge_sorter_unit_test.sv]
// ----------------------------------------------------------------------------
// interval_merge_sorter_unit_test: self-checking bench for the merge sorter
// Streams sets of intervals, predicts the sorted and merged words for each
// set and compares every output word in order, under varied idle patterns.
// ----------------------------------------------------------------------------
module interval_merge_sorter_unit_test;
  import ims_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAPACITY = MAX_INTERVALS_DEF;
  localparam int unsigned IDLE_LIMIT = 20000;

  typedef struct {
    logic signed [31:0] m_start;
    logic signed [31:0] m_end;
    logic               m_last;
    logic               m_ovf;
  } merged_word_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic signed [31:0] in_interval_start;
  logic signed [31:0] in_interval_end;
  logic               in_last_interval;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_merged_start;
  logic signed [31:0] out_merged_end;
  logic               out_last_merged;
  logic               out_capacity_exceeded;

  interval_merge_sorter_unit u_top (.*);

  // sorted copy of the current set
  logic signed [31:0] sorted_start [CAPACITY];
  logic signed [31:0] sorted_end   [CAPACITY];
  int unsigned        set_count;
  logic               set_dropped;

  merged_word_t pending_merges[$];
  int unsigned  mismatch_count = 0;
  int unsigned  idle_cycles = 0;
  int unsigned  send_idle_pct;
  int unsigned  recv_stall_pct;

  // clock
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // insert into the sorted set, merge out on the last word
  function automatic void predict_merge(logic signed [31:0] s, logic signed [31:0] e,
                                        logic last);
    int unsigned        p;
    logic signed [31:0] cs;
    logic signed [31:0] ce;
    merged_word_t       w;
    if (set_count < CAPACITY) begin
      p = set_count;
      while (p > 0 && (sorted_start[p-1] > s ||
                       (sorted_start[p-1] == s && sorted_end[p-1] > e))) begin
        sorted_start[p] = sorted_start[p-1];
        sorted_end[p]   = sorted_end[p-1];
        p--;
      end
      sorted_start[p] = s;
      sorted_end[p]   = e;
      set_count++;
    end else begin
      set_dropped = 1'b1;
    end
    if (!last) return;
    cs = sorted_start[0];
    ce = sorted_end[0];
    for (int unsigned i = 1; i < set_count; i++) begin
      if (sorted_start[i] <= ce) begin
        if (sorted_end[i] > ce) ce = sorted_end[i];
      end else begin
        w = '{cs, ce, 1'b0, set_dropped};
        pending_merges = {pending_merges, w};
        cs = sorted_start[i];
        ce = sorted_end[i];
      end
    end
    w = '{cs, ce, 1'b1, set_dropped};
    pending_merges = {pending_merges, w};
    set_count   = 0;
    set_dropped = 1'b0;
  endfunction

  // send one word, wait for acceptance
  task automatic send_interval(logic signed [31:0] s, logic signed [31:0] e, logic last);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_interval_start <= s;
    in_interval_end   <= e;
    in_last_interval  <= last;
    do @(posedge clk); while (in_stall);
    predict_merge(s, e, last);
    @(negedge clk);
  endtask

  // output stall pattern
  always @(negedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= (recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
  end

  // result checker and idle watchdog
  always @(posedge clk) begin
    merged_word_t exp_w;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && !out_stall) begin
        if (pending_merges.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected word: start %0d end %0d", out_merged_start, out_merged_end);
        end else begin
          exp_w = pending_merges.pop_front();
          if (out_merged_start !== exp_w.m_start || out_merged_end !== exp_w.m_end ||
              out_last_merged !== exp_w.m_last || out_capacity_exceeded !== exp_w.m_ovf) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: exp %0d %0d last %b ovf %b, got %0d %0d last %b ovf %b",
                       exp_w.m_start, exp_w.m_end, exp_w.m_last, exp_w.m_ovf,
                       out_merged_start, out_merged_end, out_last_merged,
                       out_capacity_exceeded);
          end
        end
      end
    end
  end

  // input goes idle, then wait for every expected word
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_merges.size() != 0) @(negedge clk);
  endtask

  function automatic logic signed [31:0] rand_point();
    case ($urandom_range(5))
      0: return 32'sh8000_0000 + $urandom_range(3);
      1: return 32'sh7fff_ffff - $urandom_range(3);
      2: return $urandom;
      default: return $signed($urandom_range(200)) - 100;
    endcase
  endfunction

  // extremes, touching, nesting, reversed, single
  task automatic test_directed();
    send_interval(32'sh8000_0000, 32'sh8000_0000, 1'b1);
    send_interval(32'sh7fff_ffff, 32'sh7fff_ffff, 1'b0);
    send_interval(32'sh8000_0000, 32'sh7fff_ffff, 1'b1);
    send_interval(10, 20, 1'b0);
    send_interval(20, 30, 1'b0);
    send_interval(31, 40, 1'b0);
    send_interval(-5, -1, 1'b1);
    send_interval(0, 100, 1'b0);
    send_interval(5, 6, 1'b0);
    send_interval(0, 50, 1'b0);
    send_interval(7, 3, 1'b0);
    send_interval(200, 150, 1'b1);
    send_interval(-1, 32'sh5555_5555, 1'b0);
    send_interval(32'sh2aaa_aaaa, -1, 1'b1);
    drain_results();
  endtask

  // more than capacity in one set, last word dropped too
  task automatic test_overflow();
    for (int i = 0; i < CAPACITY + 3; i++)
      send_interval(i * 3 - 40, i * 3 - 39 + $urandom_range(2), i == CAPACITY + 2);
    for (int i = 0; i < CAPACITY; i++)
      send_interval(-i * 5, -i * 5 + 2, i == CAPACITY - 1);
    drain_results();
  endtask

  task automatic test_random_sets(int unsigned n_items);
    int unsigned        sent;
    int unsigned        len;
    logic signed [31:0] s;
    logic signed [31:0] e;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(CAPACITY + 4, CAPACITY)
                                     : $urandom_range(8, 1);
      for (int unsigned k = 0; k < len; k++) begin
        s = rand_point();
        e = ($urandom_range(9) == 0) ? rand_point()
            : ((s > 32'sh7fff_ff00) ? s : s + $signed($urandom_range(40)));
        send_interval(s, e, k == len - 1);
        sent++;
      end
    end
  endtask

  task automatic test_idle_phases();
    send_idle_pct = 0;  recv_stall_pct = 0;  test_random_sets(45);
    send_idle_pct = 85; recv_stall_pct = 0;  test_random_sets(45);
    drain_results();
    send_idle_pct = 0;  recv_stall_pct = 85; test_random_sets(45);
    send_idle_pct = 23; recv_stall_pct = 23; test_random_sets(45);
  endtask

  // watchdog
  initial begin
    wait (rst_n);
    wait (idle_cycles >= IDLE_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_interval_start = '0;
    in_interval_end = '0;
    in_last_interval = 1'b0;
    set_count = 0;
    set_dropped = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_overflow();
    test_idle_phases();
    drain_results();
    repeat (2 * CAPACITY + 10) @(negedge clk);
    if (mismatch_count == 0 && pending_merges.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[interval_merge_sorter_unit.f]
src/ims_pkg.sv
src/ims_front.sv
src/ims_back.sv
src/interval_merge_sorter_unit.sv
src/ims_checker.sv
tb/sv/interval_merge_sorter_unit_test.sv
